>>> src/fpfa_pkg.sv
// Shared types, constants and codes for the fixed-partition fit allocator.
package fpfa_pkg;

    localparam int BLOCKS    = 16;
    localparam int PROCESSES = 16;
    localparam int SIZE_BITS = 16;

    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int PID_W  = $clog2(PROCESSES);
    localparam int BIU_W  = 5;
    localparam int POL_W  = 2;
    localparam int M_W    = (BLK_W + 1 > BIU_W) ? BLK_W + 1 : BIU_W;
    localparam int FIELD_BLK_W = 4;
    localparam int FIELD_PID_W = 4;
    localparam int CFG_IDX_W   = 1;

    // Request kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_FREED     = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [2:0] ST_LOADED    = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;
    localparam logic [2:0] ST_REJECTED  = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

    // Commands broadcast to the cells
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_LOAD  = 3'd1;
    localparam logic [2:0] CMD_ALLOC = 3'd2;
    localparam logic [2:0] CMD_FREE  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    typedef struct packed {
        logic [1:0]             kind;
        logic [FIELD_BLK_W-1:0] block_index;
        logic [FIELD_PID_W-1:0] process_id;
        logic [SIZE_BITS-1:0]   amount;
    } req_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [FIELD_BLK_W-1:0] chosen_block;
        logic [SIZE_BITS-1:0]   remaining;
    } rsp_t;

    typedef struct packed {
        logic [2:0]           op;
        logic [BLK_W-1:0]     block;
        logic [SIZE_BITS-1:0] amount;
    } cmd_t;

    // Search token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic                 active;
        logic [SIZE_BITS-1:0] need;
        logic [M_W-1:0]       m;
        logic [POL_W-1:0]     policy;
        logic [BLK_W-1:0]     start;
        logic                 any_found;
        logic [BLK_W-1:0]     any_pick;
        logic [SIZE_BITS-1:0] any_rem;
        logic                 pref_found;
        logic [BLK_W-1:0]     pref_pick;
        logic [SIZE_BITS-1:0] pref_rem;
    } probe_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_REPLY
    } state_t;

endpackage

>>> src/fixed_partition_fit_allocator_core.sv
// Top level of the fixed-partition fit allocator: sequencer plus a row of partition cells.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  req     | in        | req_valid / req_ready | kind, block_index, process_id, amount
//  rsp     | out       | rsp_valid / rsp_ready | status, chosen_block, remaining
//  cfg     | in        | cfg_we (no stall)     | cfg_index, cfg_data
//
// Load, free and clear-all requests go from the request transfer through the execute and reply
// steps to the result register, and the sequencer then returns to idle.
// Allocate adds a search step between execute and reply: the search token
// walks the cell row one partition per cycle and the pick is committed when it leaves
// the last cell.
// One request is in flight at a time; the next request transfer is taken once the
// previous result sits in the output register, even while that result waits.
// Reset clears all capacities, remaining sizes, ownership and the process table at once.
// A stalled rsp holds the result register; the sequencer waits in its reply step.
module fixed_partition_fit_allocator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  fpfa_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output fpfa_pkg::rsp_t                    rsp,
    input  logic                              cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpfa_pkg::BIU_W-1:0]        cfg_data
);

    fpfa_pkg::cmd_t   cmd;
    fpfa_pkg::probe_t chain [fpfa_pkg::BLOCKS+1];
    logic [fpfa_pkg::BLOCKS-1:0][fpfa_pkg::SIZE_BITS-1:0] caps;

    fpfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .probe_head (chain[0]),
        .probe_tail (chain[fpfa_pkg::BLOCKS]),
        .caps       (caps)
    );

    // Each cell owns one partition and advances the search token to its neighbor
    for (genvar i = 0; i < fpfa_pkg::BLOCKS; i++)
    begin : g_cell
        fpfa_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (fpfa_pkg::BLK_W'(i)),
            .cmd       (cmd),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1]),
            .capacity  (caps[i])
        );
    end

endmodule

>>> src/fpfa_cell.sv
// One partition cell: capacity, remaining size, owner flag and one search stage.
module fpfa_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [fpfa_pkg::BLK_W-1:0]         cell_idx,
    input  fpfa_pkg::cmd_t                     cmd,
    input  fpfa_pkg::probe_t                   probe_in,
    output fpfa_pkg::probe_t                   probe_out,
    output logic [fpfa_pkg::SIZE_BITS-1:0]     capacity
);

    logic [fpfa_pkg::SIZE_BITS-1:0] cap_reg, cap_next;
    logic [fpfa_pkg::SIZE_BITS-1:0] rem_reg, rem_next;
    logic                           taken_reg, taken_next;
    fpfa_pkg::probe_t               probe_reg, probe_next;

    logic hit;
    logic elig;
    logic take_any;
    logic take_pref;

    assign hit = (cmd.block == cell_idx);

    always_comb
    begin
        cap_next   = cap_reg;
        rem_next   = rem_reg;
        taken_next = taken_reg;
        case (cmd.op)
            fpfa_pkg::CMD_LOAD:
            begin
                if (hit)
                begin
                    cap_next = cmd.amount;
                    rem_next = cmd.amount;
                end
            end
            fpfa_pkg::CMD_ALLOC:
            begin
                if (hit)
                begin
                    rem_next   = rem_reg - cmd.amount;
                    taken_next = 1'b1;
                end
            end
            fpfa_pkg::CMD_FREE:
            begin
                if (hit)
                begin
                    rem_next   = cap_reg;
                    taken_next = 1'b0;
                end
            end
            fpfa_pkg::CMD_CLEAR:
            begin
                taken_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Search stage: fold this block into the running pick
    always_comb
    begin
        elig = probe_in.active && (fpfa_pkg::M_W'(cell_idx) < probe_in.m)
               && !taken_reg && (rem_reg >= probe_in.need);
        take_any = elig && (!probe_in.any_found
                   || (probe_in.policy == fpfa_pkg::POL_BEST && rem_reg < probe_in.any_rem)
                   || (probe_in.policy == fpfa_pkg::POL_WORST && rem_reg > probe_in.any_rem));
        take_pref = elig && (probe_in.policy == fpfa_pkg::POL_NEXT)
                    && (cell_idx >= probe_in.start) && !probe_in.pref_found;
        probe_next = probe_in;
        if (take_any)
        begin
            probe_next.any_found = 1'b1;
            probe_next.any_pick  = cell_idx;
            probe_next.any_rem   = rem_reg;
        end
        if (take_pref)
        begin
            probe_next.pref_found = 1'b1;
            probe_next.pref_pick  = cell_idx;
            probe_next.pref_rem   = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= '0;
            rem_reg   <= '0;
            taken_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            cap_reg   <= cap_next;
            rem_reg   <= rem_next;
            taken_reg <= taken_next;
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;
    assign capacity  = cap_reg;

endmodule

>>> src/fpfa_ctrl.sv
// Sequencer: request intake, process table, cell commands and result register.
module fpfa_ctrl (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            req_valid,
    output logic                                            req_ready,
    input  fpfa_pkg::req_t                                  req,
    output logic                                            rsp_valid,
    input  logic                                            rsp_ready,
    output fpfa_pkg::rsp_t                                  rsp,
    input  logic                                            cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]                  cfg_index,
    input  logic [fpfa_pkg::BIU_W-1:0]                      cfg_data,
    output fpfa_pkg::cmd_t                                  cmd,
    output fpfa_pkg::probe_t                                probe_head,
    input  fpfa_pkg::probe_t                                probe_tail,
    input  logic [fpfa_pkg::BLOCKS-1:0][fpfa_pkg::SIZE_BITS-1:0] caps
);

    fpfa_pkg::state_t                state_reg, state_next;
    fpfa_pkg::req_t                  item_reg;
    fpfa_pkg::rsp_t                  res_reg, res_next;
    fpfa_pkg::rsp_t                  rsp_reg, rsp_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [fpfa_pkg::POL_W-1:0]      policy_reg;
    logic [fpfa_pkg::BIU_W-1:0]      biu_reg;
    logic [fpfa_pkg::BLK_W-1:0]      nfs_reg, nfs_next;
    logic [fpfa_pkg::PROCESSES-1:0]  held_valid_reg;
    logic [fpfa_pkg::BLK_W-1:0]      held_blk_reg [fpfa_pkg::PROCESSES];

    logic                            held_set;
    logic                            held_clr;
    logic                            held_clr_all;
    logic [fpfa_pkg::BLK_W-1:0]      held_set_blk;

    logic [fpfa_pkg::M_W-1:0]        m_eff;
    logic [fpfa_pkg::PID_W-1:0]      pid_idx;
    logic                            pid_ok;
    logic                            alloc_go;
    logic [fpfa_pkg::BLK_W-1:0]      free_blk;
    logic                            free_ok;
    logic                            load_ok;
    logic                            slot_free;
    logic                            pick_found;
    logic [fpfa_pkg::BLK_W-1:0]      pick_blk;
    logic [fpfa_pkg::SIZE_BITS-1:0]  pick_rem;

    assign m_eff   = (fpfa_pkg::M_W'(biu_reg) > fpfa_pkg::M_W'(fpfa_pkg::BLOCKS))
                     ? fpfa_pkg::M_W'(fpfa_pkg::BLOCKS) : fpfa_pkg::M_W'(biu_reg);
    assign pid_idx = fpfa_pkg::PID_W'(item_reg.process_id);
    assign pid_ok  = (32'(item_reg.process_id) < fpfa_pkg::PROCESSES);
    assign alloc_go = pid_ok && !held_valid_reg[pid_idx];
    assign free_blk = held_blk_reg[pid_idx];
    assign free_ok  = pid_ok && held_valid_reg[pid_idx]
                      && (fpfa_pkg::M_W'(free_blk) < m_eff);
    assign load_ok  = (32'(item_reg.block_index) < 32'(m_eff));
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // Next fit prefers the first fit at or after the start point
    assign pick_found = probe_tail.any_found;
    assign pick_blk   = (probe_tail.policy == fpfa_pkg::POL_NEXT && probe_tail.pref_found)
                        ? probe_tail.pref_pick : probe_tail.any_pick;
    assign pick_rem   = (probe_tail.policy == fpfa_pkg::POL_NEXT && probe_tail.pref_found)
                        ? probe_tail.pref_rem : probe_tail.any_rem;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpfa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = fpfa_pkg::S_EXEC;
                end
            end
            fpfa_pkg::S_EXEC:
            begin
                if (item_reg.kind == fpfa_pkg::KIND_ALLOC && alloc_go)
                begin
                    state_next = fpfa_pkg::S_SEARCH;
                end
                else
                begin
                    state_next = fpfa_pkg::S_REPLY;
                end
            end
            fpfa_pkg::S_SEARCH:
            begin
                if (probe_tail.active)
                begin
                    state_next = fpfa_pkg::S_REPLY;
                end
            end
            fpfa_pkg::S_REPLY:
            begin
                if (slot_free)
                begin
                    state_next = fpfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fpfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        cmd            = '0;
        probe_head     = '0;
        res_next       = res_reg;
        nfs_next       = nfs_reg;
        held_set       = 1'b0;
        held_clr       = 1'b0;
        held_clr_all   = 1'b0;
        held_set_blk   = pick_blk;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            fpfa_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
            end
            fpfa_pkg::S_EXEC:
            begin
                res_next = '{status: fpfa_pkg::ST_REJECTED, chosen_block: '0, remaining: '0};
                case (item_reg.kind)
                    fpfa_pkg::KIND_LOAD:
                    begin
                        if (load_ok)
                        begin
                            cmd.op     = fpfa_pkg::CMD_LOAD;
                            cmd.block  = fpfa_pkg::BLK_W'(item_reg.block_index);
                            cmd.amount = item_reg.amount;
                            res_next   = '{status: fpfa_pkg::ST_LOADED,
                                           chosen_block: item_reg.block_index,
                                           remaining: item_reg.amount};
                        end
                    end
                    fpfa_pkg::KIND_ALLOC:
                    begin
                        if (alloc_go)
                        begin
                            probe_head.active = 1'b1;
                            probe_head.need   = item_reg.amount;
                            probe_head.m      = m_eff;
                            probe_head.policy = policy_reg;
                            probe_head.start  = (fpfa_pkg::M_W'(nfs_reg) < m_eff) ? nfs_reg : '0;
                        end
                    end
                    fpfa_pkg::KIND_FREE:
                    begin
                        res_next.status = fpfa_pkg::ST_NOT_ALLOC;
                        if (free_ok)
                        begin
                            cmd.op    = fpfa_pkg::CMD_FREE;
                            cmd.block = free_blk;
                            held_clr  = 1'b1;
                            res_next  = '{status: fpfa_pkg::ST_FREED,
                                          chosen_block: fpfa_pkg::FIELD_BLK_W'(free_blk),
                                          remaining: caps[free_blk]};
                        end
                    end
                    fpfa_pkg::KIND_CLEAR:
                    begin
                        cmd.op       = fpfa_pkg::CMD_CLEAR;
                        held_clr_all = 1'b1;
                        nfs_next     = '0;
                        res_next.status = fpfa_pkg::ST_CLEARED;
                    end
                    default:
                    begin
                    end
                endcase
            end
            fpfa_pkg::S_SEARCH:
            begin
                if (probe_tail.active)
                begin
                    if (pick_found)
                    begin
                        cmd.op     = fpfa_pkg::CMD_ALLOC;
                        cmd.block  = pick_blk;
                        cmd.amount = probe_tail.need;
                        held_set   = 1'b1;
                        nfs_next   = pick_blk;
                        res_next   = '{status: fpfa_pkg::ST_ALLOCATED,
                                       chosen_block: fpfa_pkg::FIELD_BLK_W'(pick_blk),
                                       remaining: pick_rem - probe_tail.need};
                    end
                    else
                    begin
                        res_next = '{status: fpfa_pkg::ST_NO_FIT, chosen_block: '0,
                                     remaining: '0};
                    end
                end
            end
            fpfa_pkg::S_REPLY:
            begin
                if (slot_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fpfa_pkg::S_IDLE;
            rsp_valid_reg  <= 1'b0;
            policy_reg     <= fpfa_pkg::POL_FIRST;
            biu_reg        <= fpfa_pkg::BIU_W'(16);
            nfs_reg        <= '0;
            held_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            nfs_reg       <= nfs_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fpfa_pkg::CFG_FIT_POLICY:    policy_reg <= cfg_data[fpfa_pkg::POL_W-1:0];
                    fpfa_pkg::CFG_BLOCKS_IN_USE: biu_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (held_clr_all)
            begin
                held_valid_reg <= '0;
            end
            else if (held_clr)
            begin
                held_valid_reg[pid_idx] <= 1'b0;
            end
            else if (held_set)
            begin
                held_valid_reg[pid_idx] <= 1'b1;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        if (held_set)
        begin
            held_blk_reg[pid_idx] <= held_set_blk;
        end
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Search results come back only while a search is pending
    a_probe_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        probe_tail.active |-> (state_reg == fpfa_pkg::S_SEARCH))
        else $error("search token returned outside a search");

    // Allocation commits only at the end of a search
    a_alloc_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == fpfa_pkg::CMD_ALLOC) |-> (state_reg == fpfa_pkg::S_SEARCH))
        else $error("allocation committed outside a search");

    // A reply with a free slot always shows up on the output next cycle
    a_reply_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpfa_pkg::S_REPLY && slot_free) |=> rsp_valid_reg)
        else $error("result lost on the way to the output register");

    // A search launch never overlaps an outstanding token
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        probe_head.active |-> (state_reg == fpfa_pkg::S_EXEC && !probe_tail.active))
        else $error("second search token launched");

endmodule
